// File: hw/rtl/nss_pkg.sv
// Shared types, constants and helper functions of the nine-slice span generator.
package nss_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DEST_BITS   = COORD_BITS + 2;
    localparam int TILE_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TILE_BITS-1:0] TILE_SIZE_RESET = TILE_BITS'(8);

    typedef enum logic [3:0] {
        TILE_TL = 4'd0,
        TILE_T  = 4'd1,
        TILE_TR = 4'd2,
        TILE_L  = 4'd3,
        TILE_C  = 4'd4,
        TILE_R  = 4'd5,
        TILE_BL = 4'd6,
        TILE_B  = 4'd7,
        TILE_BR = 4'd8
    } tile_t;

    typedef enum logic [1:0] {
        POS_NEAR,
        POS_MID,
        POS_FAR
    } pos_t;

    // Everything the back end needs to emit the spans of one rectangle.
    typedef struct packed {
        logic                          wide;
        logic                          tall;
        logic signed [DEST_BITS-1:0]   x;
        logic signed [DEST_BITS-1:0]   y;
        logic signed [DEST_BITS-1:0]   xs;
        logic signed [DEST_BITS-1:0]   ys;
        logic signed [DEST_BITS-1:0]   rx;
        logic signed [DEST_BITS-1:0]   by;
        logic [TILE_BITS-1:0]          lw;
        logic [TILE_BITS-1:0]          th;
        logic [TILE_BITS-1:0]          rw;
        logic [TILE_BITS-1:0]          bh;
        logic [TILE_BITS-1:0]          sx;
        logic [TILE_BITS-1:0]          sy;
        logic [COORD_BITS-1:0]         mw;
        logic [COORD_BITS-1:0]         mh;
    } nss_job_t;

    // Queue handshake between front and back.
    typedef struct packed {
        logic push;
        logic pop;
    } nss_qctl_t;

    typedef struct packed {
        logic push_ready;
        logic head_valid;
    } nss_qsts_t;

    function automatic tile_t nss_next_tile(input tile_t t, input logic wide, input logic tall);
        tile_t n;
        unique case (t)
            TILE_TL: n = wide ? TILE_T : TILE_TR;
            TILE_T:  n = TILE_TR;
            TILE_TR: n = tall ? TILE_L : TILE_BL;
            TILE_L:  n = wide ? TILE_C : TILE_R;
            TILE_C:  n = TILE_R;
            TILE_R:  n = TILE_BL;
            TILE_BL: n = wide ? TILE_B : TILE_BR;
            TILE_B:  n = TILE_BR;
            default: n = TILE_TL;
        endcase
        return n;
    endfunction

    function automatic pos_t nss_col(input tile_t t);
        pos_t p;
        unique case (t) inside
            TILE_TL, TILE_L, TILE_BL: p = POS_NEAR;
            TILE_T, TILE_C, TILE_B:   p = POS_MID;
            default:                  p = POS_FAR;
        endcase
        return p;
    endfunction

    function automatic pos_t nss_row(input tile_t t);
        pos_t p;
        unique case (t) inside
            TILE_TL, TILE_T, TILE_TR: p = POS_NEAR;
            TILE_L, TILE_C, TILE_R:   p = POS_MID;
            default:                  p = POS_FAR;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/nine_slice_span_generator.sv
// Top level of the nine-slice span generator.
//
//   channel  direction  handshake              content
//   cfg      in         cfg_valid / cfg_ready  tile_size (cfg_data)
//   in       in         in_valid / in_ready    box_x, box_y, box_width, box_height
//   out      out        out_valid / out_ready  one span per transfer, last_span on tile 8
//
// A rectangle gives 4, 6 or 9 spans; the back-end sequencer emits one span per cycle
// while the output is not stalled.
// Input is taken every cycle while the two-entry job queue has room; the first span
// goes through the stage-1 registers, the job queue and the output register.
// Reset empties front stage, queue and output register and sets tile_size to 8.
// A stall on the output holds the span; the front keeps filling the queue meanwhile.
module nine_slice_span_generator
    import nss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [TILE_BITS-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  box_x,
    input  logic signed [COORD_BITS-1:0]  box_y,
    input  logic [COORD_BITS-1:0]         box_width,
    input  logic [COORD_BITS-1:0]         box_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    tile_index,
    output logic [TILE_BITS-1:0]          source_x,
    output logic [TILE_BITS-1:0]          source_y,
    output logic signed [DEST_BITS-1:0]   dest_x,
    output logic signed [DEST_BITS-1:0]   dest_y,
    output logic [COORD_BITS-1:0]         span_width,
    output logic [COORD_BITS-1:0]         span_height,
    output logic                          repeats,
    output logic                          last_span
);

    nss_qctl_t q_ctl;
    nss_qsts_t q_sts;
    nss_job_t  q_wr_data;
    nss_job_t  q_head;
    logic      q_push, q_pop;

    assign q_ctl.push = q_push;
    assign q_ctl.pop  = q_pop;

    nss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_width  (box_width),
        .box_height (box_height),
        .q_sts      (q_sts),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    nss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .sts     (q_sts),
        .wr_data (q_wr_data),
        .head    (q_head)
    );

    nss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_sts       (q_sts),
        .head        (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tile_index  (tile_index),
        .source_x    (source_x),
        .source_y    (source_y),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .span_width  (span_width),
        .span_height (span_height),
        .repeats     (repeats),
        .last_span   (last_span)
    );

endmodule

// File: hw/rtl/nss_front.sv
// Front end: tile size register, input transfer and per-rectangle geometry.
module nss_front
    import nss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [TILE_BITS-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  box_x,
    input  logic signed [COORD_BITS-1:0]  box_y,
    input  logic [COORD_BITS-1:0]         box_width,
    input  logic [COORD_BITS-1:0]         box_height,
    input  nss_qsts_t                     q_sts,
    output logic                          q_push,
    output nss_job_t                      q_data
);

    logic [TILE_BITS-1:0]          tile_size_reg;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_wide_reg, s1_tall_reg;
    logic signed [DEST_BITS-1:0]   s1_x_reg, s1_y_reg, s1_xs_reg, s1_ys_reg;
    logic signed [DEST_BITS-1:0]   s1_xw_reg, s1_yh_reg;
    logic [TILE_BITS-1:0]          s1_lw_reg, s1_th_reg;
    logic [COORD_BITS-1:0]         s1_remw_reg, s1_remh_reg, s1_mw_reg, s1_mh_reg;

    logic                          in_xfer;
    logic                          wide, tall;
    logic [TILE_BITS-1:0]          lw, th;
    logic signed [DEST_BITS-1:0]   x_ext, y_ext;
    logic [TILE_BITS-1:0]          rw, bh;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg <= TILE_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            tile_size_reg <= cfg_data;
        end
    end

    // stage 1: compare against twice the tile size, halves and remainders
    assign in_ready = !s1_valid_reg || q_sts.push_ready;
    assign in_xfer  = in_valid && in_ready;
    assign q_push   = s1_valid_reg && q_sts.push_ready;

    assign wide  = {1'b0, box_width}  > (COORD_BITS+1)'({tile_size_reg, 1'b0});
    assign tall  = {1'b0, box_height} > (COORD_BITS+1)'({tile_size_reg, 1'b0});
    assign lw    = wide ? tile_size_reg : TILE_BITS'(box_width >> 1);
    assign th    = tall ? tile_size_reg : TILE_BITS'(box_height >> 1);
    assign x_ext = DEST_BITS'(box_x);
    assign y_ext = DEST_BITS'(box_y);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_wide_reg <= wide;
            s1_tall_reg <= tall;
            s1_x_reg    <= x_ext;
            s1_y_reg    <= y_ext;
            s1_xs_reg   <= x_ext + DEST_BITS'(tile_size_reg);
            s1_ys_reg   <= y_ext + DEST_BITS'(tile_size_reg);
            s1_xw_reg   <= x_ext + DEST_BITS'(box_width);
            s1_yh_reg   <= y_ext + DEST_BITS'(box_height);
            s1_lw_reg   <= lw;
            s1_th_reg   <= th;
            s1_remw_reg <= box_width - COORD_BITS'(lw);
            s1_remh_reg <= box_height - COORD_BITS'(th);
            s1_mw_reg   <= box_width - COORD_BITS'({tile_size_reg, 1'b0});
            s1_mh_reg   <= box_height - COORD_BITS'({tile_size_reg, 1'b0});
        end
    end

    // stage 2: far column and row, capped at the tile size; written into the queue
    assign rw = (s1_remw_reg < COORD_BITS'(tile_size_reg)) ?
                s1_remw_reg[TILE_BITS-1:0] : tile_size_reg;
    assign bh = (s1_remh_reg < COORD_BITS'(tile_size_reg)) ?
                s1_remh_reg[TILE_BITS-1:0] : tile_size_reg;

    always_comb
    begin
        q_data.wide = s1_wide_reg;
        q_data.tall = s1_tall_reg;
        q_data.x    = s1_x_reg;
        q_data.y    = s1_y_reg;
        q_data.xs   = s1_xs_reg;
        q_data.ys   = s1_ys_reg;
        q_data.rx   = s1_xw_reg - DEST_BITS'(rw);
        q_data.by   = s1_yh_reg - DEST_BITS'(bh);
        q_data.lw   = s1_lw_reg;
        q_data.th   = s1_th_reg;
        q_data.rw   = rw;
        q_data.bh   = bh;
        q_data.sx   = tile_size_reg - rw;
        q_data.sy   = tile_size_reg - bh;
        q_data.mw   = s1_mw_reg;
        q_data.mh   = s1_mh_reg;
    end

endmodule

// File: hw/rtl/nss_queue.sv
// Short job queue between front and back end.
module nss_queue
    import nss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  nss_qctl_t ctl,
    output nss_qsts_t sts,
    input  nss_job_t  wr_data,
    output nss_job_t  head
);

    nss_job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign sts.push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign sts.head_valid = (count_reg != '0);
    assign head           = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctl.push && ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/nss_back.sv
// Back end: walks the tiles of the head job and drives the output register.
module nss_back
    import nss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nss_qsts_t                     q_sts,
    input  nss_job_t                      head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    tile_index,
    output logic [TILE_BITS-1:0]          source_x,
    output logic [TILE_BITS-1:0]          source_y,
    output logic signed [DEST_BITS-1:0]   dest_x,
    output logic signed [DEST_BITS-1:0]   dest_y,
    output logic [COORD_BITS-1:0]         span_width,
    output logic [COORD_BITS-1:0]         span_height,
    output logic                          repeats,
    output logic                          last_span
);

    tile_t                         idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [3:0]                    tile_reg;
    logic [TILE_BITS-1:0]          sx_reg, sy_reg;
    logic signed [DEST_BITS-1:0]   dx_reg, dy_reg;
    logic [COORD_BITS-1:0]         w_reg, h_reg;
    logic                          rep_reg, last_reg;

    logic                          load;
    pos_t                          col, row;
    logic [TILE_BITS-1:0]          sx, sy;
    logic signed [DEST_BITS-1:0]   dx, dy;
    logic [COORD_BITS-1:0]         w, h;

    assign load  = q_sts.head_valid && (!out_valid_reg || out_ready);
    assign q_pop = load && (idx_reg == TILE_BR);
    assign col   = nss_col(idx_reg);
    assign row   = nss_row(idx_reg);

    always_comb
    begin
        unique case (col)
            POS_NEAR:
            begin
                sx = '0;
                dx = head.x;
                w  = COORD_BITS'(head.lw);
            end
            POS_MID:
            begin
                sx = '0;
                dx = head.xs;
                w  = head.mw;
            end
            default:
            begin
                sx = head.sx;
                dx = head.rx;
                w  = COORD_BITS'(head.rw);
            end
        endcase
        unique case (row)
            POS_NEAR:
            begin
                sy = '0;
                dy = head.y;
                h  = COORD_BITS'(head.th);
            end
            POS_MID:
            begin
                sy = '0;
                dy = head.ys;
                h  = head.mh;
            end
            default:
            begin
                sy = head.sy;
                dy = head.by;
                h  = COORD_BITS'(head.bh);
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = nss_next_tile(idx_reg, head.wide, head.tall);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= TILE_TL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tile_reg <= idx_reg;
            sx_reg   <= sx;
            sy_reg   <= sy;
            dx_reg   <= dx;
            dy_reg   <= dy;
            w_reg    <= w;
            h_reg    <= h;
            rep_reg  <= !((col != POS_MID) && (row != POS_MID));
            last_reg <= (idx_reg == TILE_BR);
        end
    end

    assign out_valid   = out_valid_reg;
    assign tile_index  = tile_reg;
    assign source_x    = sx_reg;
    assign source_y    = sy_reg;
    assign dest_x      = dx_reg;
    assign dest_y      = dy_reg;
    assign span_width  = w_reg;
    assign span_height = h_reg;
    assign repeats     = rep_reg;
    assign last_span   = last_reg;

endmodule

// File: hw/rtl/nss_checker.sv
// Port-level checks for the nine-slice span generator, bound to the top level.
module nss_checker
    import nss_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [3:0]                    tile_index,
    input logic [TILE_BITS-1:0]          source_x,
    input logic [TILE_BITS-1:0]          source_y,
    input logic                          repeats,
    input logic                          last_span
);

    // stalled span must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tile_index) && $stable(source_x))
        else $error("output span changed while stalled");

    a_last_br: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_span == (tile_index == TILE_BR)))
        else $error("last_span not on bottom-right tile");

    a_corner_rep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tile_index == TILE_TL || tile_index == TILE_TR ||
                      tile_index == TILE_BL || tile_index == TILE_BR) |-> !repeats)
        else $error("corner span marked as repeating");

    // only the far column and far row read at an offset
    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tile_index == TILE_TL || tile_index == TILE_L ||
                      tile_index == TILE_T) |-> source_x == '0 && source_y == '0)
        else $error("near tile with non-zero source offset");

endmodule

bind nine_slice_span_generator nss_checker u_nss_checker (.*);
